### rtl/dmpq_pkg.sv
package dmpq_pkg;

	localparam int KEY_W     = 32;
	localparam int ARITY_W   = 4;
	localparam int ARITY_MIN = 2;

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_EXTRACT  = 2'd1,
		CMD_PEEK     = 2'd2,
		CMD_INCREASE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_SMALLER   = 3'd3,
		ST_BADPOS    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROOT_WAIT,
		S_LAST_WAIT,
		S_INC_WAIT,
		S_UP_MUL,
		S_UP_PAR,
		S_UP_CMP,
		S_DN_SCAN,
		S_DN_MOVE,
		S_DONE
	} state_t;

endpackage

### rtl/dary_max_priority_queue.sv
// d-ary max-heap priority queue of 32-bit keys with tags.
// Command channel: drive command, key, tag and position with start high; the
// transaction is taken at a clock edge where busy is low. busy stays high
// until the result has been shown. Each command gives exactly one result:
// done is high for one cycle with status, out_key, out_tag and occupancy.
// The receiver cannot stall; a result not captured in that cycle is gone.
// arity is written through cfg_we/cfg_data; the user must do so only while
// the queue is idle, as the block itself does not enforce it. Values below 2
// act as 2 and values above MAX_ARITY act as MAX_ARITY. Overflow, underflow
// and bad position go straight to done. Peek reads the root; an increase
// reads the entry at position and stops if the key is smaller. Insert and a
// successful increase move the entry up a level per pass of parent address,
// parent read, compare and write, until it reaches the root or its parent is
// not smaller. Extract max reads the root, then the last entry, which
// becomes the hole at the root; if the queue is then empty it is done, else
// the children of each node are read one a cycle and the entry moves down
// to the first strictly largest child until no child beats it. The single
// read port of the heap RAM and one key compare a cycle set the pace. After
// done the queue returns to idle and takes the next command. Reset empties
// the queue and sets arity to 2; the heap RAM needs no clearing.
module dary_max_priority_queue #(
	parameter int CAPACITY  = 1024,
	parameter int MAX_ARITY = 8,
	parameter int TAG_BITS  = 16,
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dmpq_pkg::ARITY_W-1:0]  cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    command,
	input  logic [dmpq_pkg::KEY_W-1:0]    key,
	input  logic [TAG_BITS-1:0]           tag,
	input  logic [CNT_W-1:0]              position,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [dmpq_pkg::KEY_W-1:0]    out_key,
	output logic [TAG_BITS-1:0]           out_tag,
	output logic [CNT_W-1:0]              occupancy
);

	localparam int KEY_W = dmpq_pkg::KEY_W;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int AR_W  = $clog2(MAX_ARITY + 1);
	localparam int DIV_W = $clog2(MAX_ARITY);
	localparam int SH    = IDX_W + DIV_W;
	localparam int PW    = IDX_W + SH;
	localparam int CH_W  = IDX_W + AR_W + 1;
	localparam int ENT_W = KEY_W + TAG_BITS;

	dmpq_pkg::state_t  state_q, state_d;
	dmpq_pkg::cmd_t    in_cmd, cmd_q;
	dmpq_pkg::status_t status_q;

	logic [dmpq_pkg::ARITY_W-1:0] arity_q;
	logic [CNT_W-1:0]             count_q;
	logic                         pend_q;

	logic [KEY_W-1:0]    ent_key_q, best_key_q, out_key_q;
	logic [TAG_BITS-1:0] ent_tag_q, best_tag_q, out_tag_q;
	logic [IDX_W-1:0]    pos_q, par_q, best_idx_q, pend_idx_q;
	logic [CH_W-1:0]     child_q;
	logic [AR_W-1:0]     k_q;
	logic [PW-1:0]       prod_q;

	logic [AR_W-1:0]         eff_arity;
	logic [dmpq_pkg::ARITY_W:0] ar_x;
	logic [SH-1:0]           recip [MAX_ARITY+1];
	logic [IDX_W-1:0]        par;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [ENT_W-1:0]  ram_wdata, rd_data;
	logic [KEY_W-1:0]  rd_key;
	logic [TAG_BITS-1:0] rd_tag;

	logic full, empty, bad_pos, key_smaller, par_less, issue_ok, scan_done, child_better;

	// floor(n/d) = (n * ceil(2^SH/d)) >> SH for every n below 2^IDX_W
	for (genvar g = 0; g <= MAX_ARITY; g++) begin : g_recip
		if (g < dmpq_pkg::ARITY_MIN) begin : g_unused
			assign recip[g] = '0;
		end else begin : g_used
			localparam longint unsigned RC = ((64'd1 << SH) + g - 1) / g;
			assign recip[g] = SH'(RC);
		end
	end

	always_comb begin
		ar_x = {1'b0, arity_q};
		if (ar_x < dmpq_pkg::ARITY_MIN) begin
			eff_arity = AR_W'(dmpq_pkg::ARITY_MIN);
		end else if (ar_x > MAX_ARITY) begin
			eff_arity = AR_W'(MAX_ARITY);
		end else begin
			eff_arity = AR_W'(ar_x);
		end
	end

	dmpq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(CAPACITY)
	) u_heap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	assign in_cmd       = dmpq_pkg::cmd_t'(command);
	assign rd_key       = rd_data[ENT_W-1 -: KEY_W];
	assign rd_tag       = rd_data[TAG_BITS-1:0];
	assign par          = prod_q[SH +: IDX_W];
	assign full         = (count_q == CNT_W'(CAPACITY));
	assign empty        = (count_q == '0);
	assign bad_pos      = (position == '0) || (position > count_q);
	assign key_smaller  = (ent_key_q < rd_key);
	assign par_less     = (rd_key < ent_key_q);
	assign issue_ok     = (k_q < eff_arity) && (child_q < CH_W'(count_q));
	assign scan_done    = !issue_ok && !pend_q;
	assign child_better = pend_q && (rd_key > best_key_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dmpq_pkg::S_IDLE: begin
				if (start) begin
					unique case (in_cmd)
						dmpq_pkg::CMD_INSERT:
							state_d = full ? dmpq_pkg::S_DONE : dmpq_pkg::S_UP_MUL;
						dmpq_pkg::CMD_EXTRACT, dmpq_pkg::CMD_PEEK:
							state_d = empty ? dmpq_pkg::S_DONE : dmpq_pkg::S_ROOT_WAIT;
						dmpq_pkg::CMD_INCREASE:
							state_d = bad_pos ? dmpq_pkg::S_DONE : dmpq_pkg::S_INC_WAIT;
						default: state_d = dmpq_pkg::S_DONE;
					endcase
				end
			end
			dmpq_pkg::S_ROOT_WAIT:
				state_d = (cmd_q == dmpq_pkg::CMD_PEEK) ? dmpq_pkg::S_DONE
				                                        : dmpq_pkg::S_LAST_WAIT;
			dmpq_pkg::S_LAST_WAIT:
				state_d = empty ? dmpq_pkg::S_DONE : dmpq_pkg::S_DN_SCAN;
			dmpq_pkg::S_INC_WAIT:
				state_d = key_smaller ? dmpq_pkg::S_DONE : dmpq_pkg::S_UP_MUL;
			dmpq_pkg::S_UP_MUL:
				state_d = (pos_q == '0) ? dmpq_pkg::S_DONE : dmpq_pkg::S_UP_PAR;
			dmpq_pkg::S_UP_PAR:
				state_d = dmpq_pkg::S_UP_CMP;
			dmpq_pkg::S_UP_CMP:
				state_d = par_less ? dmpq_pkg::S_UP_MUL : dmpq_pkg::S_DONE;
			dmpq_pkg::S_DN_SCAN:
				if (scan_done) state_d = dmpq_pkg::S_DN_MOVE;
			dmpq_pkg::S_DN_MOVE:
				state_d = (best_idx_q == pos_q) ? dmpq_pkg::S_DONE : dmpq_pkg::S_DN_SCAN;
			dmpq_pkg::S_DONE:
				state_d = dmpq_pkg::S_IDLE;
			default:
				state_d = dmpq_pkg::S_IDLE;
		endcase
	end

	// outputs and RAM control
	always_comb begin
		busy      = (state_q != dmpq_pkg::S_IDLE);
		done      = (state_q == dmpq_pkg::S_DONE);
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = {ent_key_q, ent_tag_q};
		ram_raddr = '0;
		unique case (state_q)
			dmpq_pkg::S_IDLE:
				if (in_cmd == dmpq_pkg::CMD_INCREASE) ram_raddr = IDX_W'(position - 1'b1);
			dmpq_pkg::S_ROOT_WAIT:
				ram_raddr = IDX_W'(count_q - 1'b1);
			dmpq_pkg::S_UP_MUL:
				ram_we = (pos_q == '0);
			dmpq_pkg::S_UP_PAR:
				ram_raddr = par;
			dmpq_pkg::S_UP_CMP: begin
				ram_we = 1'b1;
				if (par_less) ram_wdata = rd_data;
			end
			dmpq_pkg::S_DN_SCAN:
				ram_raddr = child_q[IDX_W-1:0];
			dmpq_pkg::S_DN_MOVE: begin
				ram_we = 1'b1;
				if (best_idx_q != pos_q) ram_wdata = {best_key_q, best_tag_q};
			end
			default: ram_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmpq_pkg::S_IDLE;
			arity_q <= dmpq_pkg::ARITY_W'(dmpq_pkg::ARITY_MIN);
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) arity_q <= cfg_data;
			if (state_q == dmpq_pkg::S_IDLE && start && in_cmd == dmpq_pkg::CMD_INSERT && !full) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == dmpq_pkg::S_ROOT_WAIT && cmd_q == dmpq_pkg::CMD_EXTRACT) begin
				count_q <= count_q - 1'b1;
			end
			pend_q <= (state_q == dmpq_pkg::S_DN_SCAN) && issue_ok;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			dmpq_pkg::S_IDLE: begin
				if (start) begin
					cmd_q     <= in_cmd;
					ent_key_q <= key;
					ent_tag_q <= tag;
					out_key_q <= '0;
					out_tag_q <= '0;
					pos_q     <= (in_cmd == dmpq_pkg::CMD_INSERT) ? IDX_W'(count_q)
					                                              : IDX_W'(position - 1'b1);
					status_q  <= dmpq_pkg::ST_OK;
					unique case (in_cmd)
						dmpq_pkg::CMD_INSERT:
							if (full) status_q <= dmpq_pkg::ST_OVERFLOW;
						dmpq_pkg::CMD_EXTRACT, dmpq_pkg::CMD_PEEK:
							if (empty) status_q <= dmpq_pkg::ST_UNDERFLOW;
						dmpq_pkg::CMD_INCREASE:
							if (bad_pos) status_q <= dmpq_pkg::ST_BADPOS;
						default: status_q <= dmpq_pkg::ST_OK;
					endcase
				end
			end
			dmpq_pkg::S_ROOT_WAIT: begin
				out_key_q <= rd_key;
				out_tag_q <= rd_tag;
			end
			dmpq_pkg::S_LAST_WAIT: begin
				// last entry becomes the hole at the root
				ent_key_q  <= rd_key;
				ent_tag_q  <= rd_tag;
				pos_q      <= '0;
				best_idx_q <= '0;
				best_key_q <= rd_key;
				child_q    <= CH_W'(1);
				k_q        <= '0;
			end
			dmpq_pkg::S_INC_WAIT: begin
				if (key_smaller) status_q <= dmpq_pkg::ST_SMALLER;
				else ent_tag_q <= rd_tag;
			end
			dmpq_pkg::S_UP_MUL:
				prod_q <= PW'(pos_q - 1'b1) * PW'(recip[eff_arity]);
			dmpq_pkg::S_UP_PAR:
				par_q <= par;
			dmpq_pkg::S_UP_CMP:
				if (par_less) pos_q <= par_q;
			dmpq_pkg::S_DN_SCAN: begin
				if (issue_ok) begin
					pend_idx_q <= child_q[IDX_W-1:0];
					child_q    <= child_q + 1'b1;
					k_q        <= k_q + 1'b1;
				end
				// strictly larger only: first of equal children wins
				if (child_better) begin
					best_idx_q <= pend_idx_q;
					best_key_q <= rd_key;
					best_tag_q <= rd_tag;
				end
			end
			dmpq_pkg::S_DN_MOVE: begin
				if (best_idx_q != pos_q) begin
					pos_q      <= best_idx_q;
					child_q    <= CH_W'(best_idx_q) * CH_W'(eff_arity) + CH_W'(1);
					k_q        <= '0;
					best_key_q <= ent_key_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign status    = status_q;
	assign out_key   = out_key_q;
	assign out_tag   = out_tag_q;
	assign occupancy = count_q;

endmodule

### rtl/dmpq_ram.sv
module dmpq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### tb/dmpq_checker.sv
`timescale 1ns / 1ps

module dmpq_checker #(
	parameter int CAPACITY  = 1024,
	parameter int MAX_ARITY = 8,
	parameter int TAG_BITS  = 16,
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dmpq_pkg::ARITY_W-1:0]   cfg_data,
	input  logic                           start,
	input  logic                           busy,
	input  logic [1:0]                     command,
	input  logic [dmpq_pkg::KEY_W-1:0]     key,
	input  logic [TAG_BITS-1:0]            tag,
	input  logic [CNT_W-1:0]               position,
	input  logic                           done,
	input  logic [2:0]                     status,
	input  logic [dmpq_pkg::KEY_W-1:0]     out_key,
	input  logic [TAG_BITS-1:0]            out_tag,
	input  logic [CNT_W-1:0]               occupancy,
	output int                             mismatch_count,
	output int                             open_results
);

	localparam int KEY_W = dmpq_pkg::KEY_W;

	typedef struct {
		dmpq_pkg::status_t     st;
		logic [KEY_W-1:0]      k;
		logic [TAG_BITS-1:0]   t;
		logic [CNT_W-1:0]      occ;
	} queue_result_t;

	logic [KEY_W-1:0]    pq_key [CAPACITY];
	logic [TAG_BITS-1:0] pq_tag [CAPACITY];
	int unsigned         pq_count;
	logic [dmpq_pkg::ARITY_W-1:0] arity_raw;

	queue_result_t awaited_results[$];
	queue_result_t head;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// clamp the written arity into the range the queue honors
	function automatic int unsigned branch_factor();
		int unsigned d;
		d = 32'(arity_raw);
		if (d < dmpq_pkg::ARITY_MIN)
			d = dmpq_pkg::ARITY_MIN;
		if (d > MAX_ARITY)
			d = MAX_ARITY;
		return d;
	endfunction

	function automatic void swap_entries(int unsigned a, int unsigned b);
		logic [KEY_W-1:0]    tk;
		logic [TAG_BITS-1:0] tt;
		tk = pq_key[a];
		tt = pq_tag[a];
		pq_key[a] = pq_key[b];
		pq_tag[a] = pq_tag[b];
		pq_key[b] = tk;
		pq_tag[b] = tt;
	endfunction

	function automatic void float_up(int unsigned idx);
		int unsigned d, up;
		d = branch_factor();
		while (idx > 0) begin
			up = (idx - 1) / d;
			if (!(pq_key[up] < pq_key[idx]))
				break;
			swap_entries(up, idx);
			idx = up;
		end
	endfunction

	// follow the first strictly largest child until no child beats the entry
	function automatic void sink_down(int unsigned idx);
		int unsigned d, best, first;
		d = branch_factor();
		while (idx < pq_count) begin
			best = idx;
			first = idx * d + 1;
			for (int unsigned c = 0; c < d; c++) begin
				if (first + c < pq_count && pq_key[first + c] > pq_key[best])
					best = first + c;
			end
			if (best == idx)
				break;
			swap_entries(idx, best);
			idx = best;
		end
	endfunction

	function automatic queue_result_t apply_heap_command(dmpq_pkg::cmd_t op,
			logic [KEY_W-1:0] k, logic [TAG_BITS-1:0] t, logic [CNT_W-1:0] p);
		queue_result_t r;
		r.st = dmpq_pkg::ST_OK;
		r.k = '0;
		r.t = '0;
		case (op)
			dmpq_pkg::CMD_INSERT: begin
				if (pq_count >= CAPACITY) begin
					r.st = dmpq_pkg::ST_OVERFLOW;
				end else begin
					pq_key[pq_count] = k;
					pq_tag[pq_count] = t;
					pq_count++;
					float_up(pq_count - 1);
				end
			end
			dmpq_pkg::CMD_EXTRACT, dmpq_pkg::CMD_PEEK: begin
				if (pq_count == 0) begin
					r.st = dmpq_pkg::ST_UNDERFLOW;
				end else begin
					r.k = pq_key[0];
					r.t = pq_tag[0];
					if (op == dmpq_pkg::CMD_EXTRACT) begin
						pq_count--;
						pq_key[0] = pq_key[pq_count];
						pq_tag[0] = pq_tag[pq_count];
						sink_down(0);
					end
				end
			end
			default: begin
				if (p == 0 || p > pq_count) begin
					r.st = dmpq_pkg::ST_BADPOS;
				end else if (k < pq_key[p - 1]) begin
					r.st = dmpq_pkg::ST_SMALLER;
				end else begin
					pq_key[p - 1] = k;
					float_up(p - 1);
				end
			end
		endcase
		r.occ = pq_count[CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_results.delete();
			pq_count = 0;
			arity_raw = dmpq_pkg::ARITY_W'(dmpq_pkg::ARITY_MIN);
			mismatch_count = 0;
			open_results = 0;
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result, occupancy", 64'(occupancy), 64'(0));
				end else begin
					head = awaited_results.pop_front();
					if (status !== head.st)
						report_mismatch("status", 64'(status), 64'(head.st));
					if (out_key !== head.k)
						report_mismatch("out_key", 64'(out_key), 64'(head.k));
					if (out_tag !== head.t)
						report_mismatch("out_tag", 64'(out_tag), 64'(head.t));
					if (occupancy !== head.occ)
						report_mismatch("occupancy", 64'(occupancy), 64'(head.occ));
				end
			end
			if (cfg_we)
				arity_raw = cfg_data;
			if (start && !busy)
				awaited_results.insert(awaited_results.size(),
					apply_heap_command(dmpq_pkg::cmd_t'(command), key, tag, position));
			open_results = awaited_results.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int CAP   = 1024;
	localparam int MAXA  = 8;
	localparam int TAGW  = 16;
	localparam int KEY_W = dmpq_pkg::KEY_W;
	localparam int AR_W  = dmpq_pkg::ARITY_W;
	localparam int CNT_W = $clog2(CAP + 1);
	localparam int RANDOM_SEGMENTS = 12;
	localparam int SEGMENT_ITEMS   = 22;
	localparam int FILL_ITEMS      = 64;
	localparam logic [AR_W-1:0] ARITY_PLAN [RANDOM_SEGMENTS] =
		'{4'd0, 4'd2, 4'd15, 4'd3, 4'd1, 4'd8, 4'd9, 4'd5, 4'd4, 4'd6, 4'd7, 4'd2};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [AR_W-1:0]     cfg_data;
	logic                start;
	logic                busy;
	logic [1:0]          command;
	logic [KEY_W-1:0]    key;
	logic [TAGW-1:0]     tag;
	logic [CNT_W-1:0]    position;
	logic                done;
	logic [2:0]          status;
	logic [KEY_W-1:0]    out_key;
	logic [TAGW-1:0]     out_tag;
	logic [CNT_W-1:0]    occupancy;
	int                  mismatches;
	int                  open_results;

	int                  idle_pct;
	int unsigned         heap_fill;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	dary_max_priority_queue #(
		.CAPACITY  (CAP),
		.MAX_ARITY (MAXA),
		.TAG_BITS  (TAGW)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.key       (key),
		.tag       (tag),
		.position  (position),
		.done      (done),
		.status    (status),
		.out_key   (out_key),
		.out_tag   (out_tag),
		.occupancy (occupancy)
	);

	dmpq_checker #(
		.CAPACITY  (CAP),
		.MAX_ARITY (MAXA),
		.TAG_BITS  (TAGW)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.key            (key),
		.tag            (tag),
		.position       (position),
		.done           (done),
		.status         (status),
		.out_key        (out_key),
		.out_tag        (out_tag),
		.occupancy      (occupancy),
		.mismatch_count (mismatches),
		.open_results   (open_results)
	);

	// call at a falling edge; returns at the falling edge after the edge that takes the transaction
	task automatic issue(input dmpq_pkg::cmd_t op, input logic [KEY_W-1:0] k,
			input logic [TAGW-1:0] t, input logic [CNT_W-1:0] p);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			command <= 2'($urandom);
			key <= $urandom;
			tag <= TAGW'($urandom);
			position <= CNT_W'($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		command <= op;
		key <= k;
		tag <= t;
		position <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		if (op == dmpq_pkg::CMD_INSERT && heap_fill < CAP)
			heap_fill++;
		if (op == dmpq_pkg::CMD_EXTRACT && heap_fill > 0)
			heap_fill--;
	endtask

	// drain, then write arity while the queue sits idle
	task automatic set_arity(input logic [AR_W-1:0] value);
		start <= 1'b0;
		while (open_results != 0 || busy)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= AR_W'($urandom);
	endtask

	task automatic send_random_command();
		int unsigned      sel;
		logic [KEY_W-1:0] k;
		logic [CNT_W-1:0] p;
		sel = $urandom_range(99);
		k = $urandom;
		p = CNT_W'($urandom);
		if (sel < 40) begin
			case ($urandom_range(3))
				1: k = $urandom_range(15);
				2: k = $urandom_range(1) ? '1 : '0;
				default: ;
			endcase
			issue(dmpq_pkg::CMD_INSERT, k, TAGW'($urandom), p);
		end else if (sel < 65) begin
			issue(dmpq_pkg::CMD_EXTRACT, k, TAGW'($urandom), p);
		end else if (sel < 75) begin
			issue(dmpq_pkg::CMD_PEEK, k, TAGW'($urandom), p);
		end else begin
			if (heap_fill > 0 && $urandom_range(99) < 80)
				p = CNT_W'($urandom_range(heap_fill, 1));
			// bias half the new keys high so most raises succeed
			if ($urandom_range(1))
				k[KEY_W-1 -: 16] = '1;
			issue(dmpq_pkg::CMD_INCREASE, k, TAGW'($urandom), p);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		start = 1'b0;
		command = dmpq_pkg::CMD_INSERT;
		key = '0;
		tag = '0;
		position = '0;
		idle_pct = 6;
		heap_fill = 0;
		repeat (8)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty queue errors, extreme fields, ties, raise rules, at reset arity
		issue(dmpq_pkg::CMD_PEEK, '1, '1, '1);
		issue(dmpq_pkg::CMD_EXTRACT, '0, '0, '0);
		issue(dmpq_pkg::CMD_INCREASE, '1, '0, 11'd1);
		issue(dmpq_pkg::CMD_INSERT, '0, '0, '0);
		issue(dmpq_pkg::CMD_INSERT, '1, '1, '1);
		issue(dmpq_pkg::CMD_INSERT, 32'd5, 16'h1234, '0);
		issue(dmpq_pkg::CMD_INSERT, 32'd5, 16'h4321, '0);
		issue(dmpq_pkg::CMD_INSERT, 32'd5, 16'h0001, '0);
		issue(dmpq_pkg::CMD_PEEK, '0, '0, '0);
		issue(dmpq_pkg::CMD_INCREASE, '1, '0, 11'd0);
		issue(dmpq_pkg::CMD_INCREASE, '1, '0, '1);
		issue(dmpq_pkg::CMD_INCREASE, '1, '0, 11'd6);
		issue(dmpq_pkg::CMD_INCREASE, 32'd7, '0, 11'd1);
		issue(dmpq_pkg::CMD_INCREASE, '1, '0, 11'd1);
		issue(dmpq_pkg::CMD_INCREASE, 32'd6, '0, 11'd5);
		issue(dmpq_pkg::CMD_INCREASE, 32'd5, '0, 11'd4);
		repeat (5)
			issue(dmpq_pkg::CMD_EXTRACT, '0, '0, '0);
		issue(dmpq_pkg::CMD_EXTRACT, '0, '0, '0);
		issue(dmpq_pkg::CMD_PEEK, '0, '0, '0);

		// build a heap with many ties at the widest arity, hit the top position
		// and one past it, then drain
		set_arity(4'd8);
		while (heap_fill < FILL_ITEMS)
			issue(dmpq_pkg::CMD_INSERT, $urandom_range(255), TAGW'($urandom),
				CNT_W'($urandom));
		issue(dmpq_pkg::CMD_PEEK, '0, '0, '0);
		issue(dmpq_pkg::CMD_INCREASE, '1, '0, CNT_W'(FILL_ITEMS));
		issue(dmpq_pkg::CMD_INCREASE, '1, '0, CNT_W'(FILL_ITEMS + 1));
		while (heap_fill > 0)
			issue(dmpq_pkg::CMD_EXTRACT, $urandom, TAGW'($urandom), CNT_W'($urandom));
		issue(dmpq_pkg::CMD_EXTRACT, '0, '0, '0);

		for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
			idle_pct = (seg < 4) ? 6 : (seg < 8) ? 80 : 0;
			set_arity(ARITY_PLAN[seg]);
			repeat (SEGMENT_ITEMS)
				send_random_command();
		end

		start <= 1'b0;
		while (open_results != 0)
			@(negedge clk);
		repeat (100)
			@(negedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
